/* src/packed_10bit_unpack_auto_gain_top_defines.svh */
// ----------------------------------------------------------------------------
// packed 10-bit unpack assertion macros
// assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef PACKED_10BIT_UNPACK_AUTO_GAIN_TOP_DEFINES_SVH
`define PACKED_10BIT_UNPACK_AUTO_GAIN_TOP_DEFINES_SVH

// clocked check, off while reset is high
`define P10AG_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("p10ag check failed");

// clocked check, active during reset too
`define P10AG_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("p10ag check failed");

`endif

/* src/p10ag_pkg.sv */
// ----------------------------------------------------------------------------
// p10ag_pkg
// types, constants and helpers of the packed 10-bit unpacker
// ----------------------------------------------------------------------------
package p10ag_pkg;

  localparam int PIX_W     = 10;
  localparam int OUT_W     = 16;
  localparam int LANES     = 4;
  localparam int GROUP_W   = PIX_W * LANES;
  localparam int NUM_W     = 2 * PIX_W;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] FULL_SCALE = 10'h3ff;
  localparam logic [PIX_W-1:0] MAX_RESET  = 10'd1;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  typedef struct packed {
    logic               op;
    logic               frame_start;
    logic [GROUP_W-1:0] packed_group;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] pixel0;
    logic [OUT_W-1:0] pixel1;
    logic [OUT_W-1:0] pixel2;
    logic [OUT_W-1:0] pixel3;
  } out_item_t;

  typedef struct packed {
    logic load_meas;
    logic load_conv;
    logic step;
    logic store_out;
  } dp_cmd_t;

  typedef struct packed {
    logic gain_on;
  } dp_stat_t;

  function automatic logic [OUT_W-1:0] widen(input logic [PIX_W-1:0] v);
    return {v, v[PIX_W-1:PIX_W-(OUT_W-PIX_W)]};
  endfunction

endpackage

/* src/p10ag_dp.sv */
// ----------------------------------------------------------------------------
// p10ag_dp
// datapath: frame maximum, four restoring divider lanes, output register
// ----------------------------------------------------------------------------
module p10ag_dp import p10ag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  logic                             gain_on;
  logic [PIX_W-1:0]                 frame_max;
  logic [PIX_W-1:0]                 frame_max_next;
  logic [LANES-1:0][PIX_W-1:0]      pix;
  logic [LANES-1:0][PIX_W-1:0]      rem;
  logic [LANES-1:0][PIX_W-1:0]      quo;
  logic [LANES-1:0]                 sat;
  logic [LANES-1:0][PIX_W-1:0]      in_pix;
  logic [LANES-1:0][NUM_W-1:0]      num;
  logic [LANES-1:0][PIX_W:0]        trial;
  logic [LANES-1:0]                 fits;
  logic [LANES-1:0][PIX_W-1:0]      res;
  logic [PIX_W-1:0]                 max01;
  logic [PIX_W-1:0]                 max23;
  logic [PIX_W-1:0]                 max_grp;
  logic [PIX_W-1:0]                 max_base;

  assign stat.gain_on = gain_on;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      in_pix[k] = in_data.packed_group[k*PIX_W +: PIX_W];
      // p * 1023 as (p << 10) - p
      num[k]    = {in_pix[k], {PIX_W{1'b0}}} - NUM_W'(in_pix[k]);
      trial[k]  = {rem[k], quo[k][PIX_W-1]};
      fits[k]   = trial[k] >= {1'b0, frame_max};
      if (!gain_on) begin
        res[k] = pix[k];
      end else if (sat[k]) begin
        res[k] = FULL_SCALE;
      end else begin
        res[k] = quo[k];
      end
    end
  end

  always_comb begin
    max01          = (in_pix[0] > in_pix[1]) ? in_pix[0] : in_pix[1];
    max23          = (in_pix[2] > in_pix[3]) ? in_pix[2] : in_pix[3];
    max_grp        = (max01 > max23) ? max01 : max23;
    max_base       = in_data.frame_start ? MAX_RESET : frame_max;
    frame_max_next = (max_grp > max_base) ? max_grp : max_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_on   <= 1'b0;
      frame_max <= MAX_RESET;
    end else begin
      if (cfg_wr_en) begin
        gain_on <= cfg_wr_data;
      end
      if (cmd.load_meas) begin
        frame_max <= frame_max_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (cmd.load_conv) begin
        pix[k] <= in_pix[k];
        // above the maximum the quotient exceeds full scale
        sat[k] <= in_pix[k] > frame_max;
        rem[k] <= num[k][NUM_W-1:PIX_W];
        quo[k] <= num[k][PIX_W-1:0];
      end else if (cmd.step) begin
        if (fits[k]) begin
          rem[k] <= PIX_W'(trial[k] - {1'b0, frame_max});
        end else begin
          rem[k] <= trial[k][PIX_W-1:0];
        end
        quo[k] <= {quo[k][PIX_W-2:0], fits[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_out) begin
      out_data.pixel0 <= widen(res[0]);
      out_data.pixel1 <= widen(res[1]);
      out_data.pixel2 <= widen(res[2]);
      out_data.pixel3 <= widen(res[3]);
    end
  end

endmodule

/* src/p10ag_ctrl.sv */
// ----------------------------------------------------------------------------
// p10ag_ctrl
// controller: input acceptance, divider sequencing, output register valid
// ----------------------------------------------------------------------------
module p10ag_ctrl import p10ag_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             in_acc;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.load_meas = in_acc && (in_op == OP_MEASURE);
    cmd.load_conv = in_acc && (in_op == OP_CONVERT);
    cmd.step      = (state == S_DIV);
    cmd.store_out = (state == S_DONE) && out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load_conv) begin
          state_next = stat.gain_on ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.store_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/packed_10bit_unpack_auto_gain_top.sv */
// ----------------------------------------------------------------------------
// packed_10bit_unpack_auto_gain_top
// packed 10-bit to 16-bit gray unpacker with frame-maximum auto gain
// ----------------------------------------------------------------------------
// Each transaction carries five bytes holding four little-endian 10-bit
// pixels. A measure transaction folds the pixels into the frame maximum
// without leaving the idle state, so measures stream back to back. A convert
// transaction produces one output of four 16-bit pixels; it holds the
// input off until that output is stored, and with auto gain on first
// lets four restoring divider lanes run 10 steps in parallel to form
// floor(p * 1023 / max), saturated at 1023. A finished output sits in an
// output register, so a following measure is taken while it waits; a
// second convert completes once that register is free.
// ----------------------------------------------------------------------------
module packed_10bit_unpack_auto_gain_top import p10ag_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  p10ag_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  p10ag_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

/* src/p10ag_chk.sv */
// ----------------------------------------------------------------------------
// p10ag_chk
// port-level checks of the unpacker, bound to the top level
// ----------------------------------------------------------------------------
`include "packed_10bit_unpack_auto_gain_top_defines.svh"

module p10ag_chk import p10ag_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `P10AG_ASSERT_ALWAYS(a_rst_no_out, clk, rst |=> !out_valid)

  `P10AG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))

  `P10AG_ASSERT(a_meas_no_out, clk, rst, in_valid && in_ready && (in_data.op == OP_MEASURE) && !out_valid |=> !out_valid)

  `P10AG_ASSERT(a_conv_busy, clk, rst, in_valid && in_ready && (in_data.op == OP_CONVERT) |=> !in_ready)

endmodule

bind packed_10bit_unpack_auto_gain_top p10ag_chk u_p10ag_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed 10-bit unpack auto gain testbench
// drives measure and convert transactions through a valid/ready driver,
// predicts each 16-bit pixel group in step with input acceptance, and
// checks every output transaction against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
  import p10ag_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  packed_10bit_unpack_auto_gain_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  in_item_t    groups_pending[$];
  out_item_t   pixels_due[$];
  logic [9:0]  peak_level = 10'd1;
  logic        gain_enabled = 1'b0;
  int unsigned groups_queued = 0;
  int unsigned groups_taken = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  logic        in_taken = 1'b0;
  bit          burst_mode = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_500_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (burst_mode) begin
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [15:0] widen10(input logic [9:0] v);
    logic [15:0] w;
    w = ({6'd0, v} << 6) | ({6'd0, v} >> 4);
    return w;
  endfunction

  function automatic logic [9:0] gain_scale(input logic [9:0] p);
    int unsigned q;
    q = (int'(p) * 1023) / int'(peak_level);
    if (q > 1023) begin
      q = 1023;
    end
    return q[9:0];
  endfunction

  // updates the running peak on measure, yields four pixels on convert
  function automatic void unpack_step(input in_item_t it, output bit has_px,
                                      output out_item_t px);
    logic [9:0]  p [4];
    logic [15:0] w [4];
    for (int k = 0; k < 4; k++) begin
      p[k] = it.packed_group[10*k +: 10];
    end
    has_px = 1'b0;
    px = '0;
    if (it.op == OP_MEASURE) begin
      if (it.frame_start) begin
        peak_level = 10'd1;
      end
      for (int k = 0; k < 4; k++) begin
        if (p[k] > peak_level) begin
          peak_level = p[k];
        end
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        w[k] = widen10(gain_enabled ? gain_scale(p[k]) : p[k]);
      end
      px.pixel0 = w[0];
      px.pixel1 = w[1];
      px.pixel2 = w[2];
      px.pixel3 = w[3];
      has_px = 1'b1;
    end
  endfunction

  function automatic logic [39:0] pack4(input logic [9:0] p0, input logic [9:0] p1,
                                        input logic [9:0] p2, input logic [9:0] p3);
    return {p3, p2, p1, p0};
  endfunction

  function automatic logic [39:0] rand_group(input int unsigned cap);
    return pack4(10'($urandom_range(cap, 0)), 10'($urandom_range(cap, 0)),
                 10'($urandom_range(cap, 0)), 10'($urandom_range(cap, 0)));
  endfunction

  task automatic offer(input logic op, input logic fs, input logic [39:0] grp);
    in_item_t it;
    it.op = op;
    it.frame_start = fs;
    it.packed_group = grp;
    groups_pending.push_back(it);
    groups_queued++;
  endtask

  task automatic settle();
    wait (groups_taken == groups_queued);
    wait (pixels_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gain(input logic v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop_at, cap, nm, nc;
    logic [63:0] raw;
    stop_at = groups_queued + count;
    while (groups_queued < stop_at) begin
      if ($urandom_range(99, 0) < 85) begin
        cap = ($urandom_range(3, 0) == 0) ? 1023 : $urandom_range(1023, 0);
        nm = $urandom_range(6, 1);
        nc = $urandom_range(6, 1);
        for (int i = 0; i < nm; i++) begin
          offer(OP_MEASURE, i == 0, rand_group(cap));
        end
        for (int i = 0; i < nc; i++) begin
          offer(OP_CONVERT, 1'($urandom_range(1, 0)),
                $urandom_range(1, 0) ? rand_group(cap) : rand_group(1023));
        end
      end else begin
        raw = {$urandom(), $urandom()};
        offer(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), raw[39:0]);
      end
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (groups_pending.size() > 0) begin
        in_data <= groups_pending.pop_front();
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back up the block
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      out_ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      out_ready <= 1'b1;
      recv_stall <= gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    bit          has_px;
    out_item_t   px;
    out_item_t   want;
    logic [15:0] w [4];
    logic [15:0] h [4];
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_enabled = cfg_wr_data;
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        unpack_step(in_data, has_px, px);
        if (has_px) begin
          pixels_due.push_back(px);
        end
        groups_taken++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pixels_due.size() == 0) begin
          errors++;
          $display("%0t unexpected output transaction %h", $time, out_data);
        end else begin
          want = pixels_due.pop_front();
          w = '{want.pixel0, want.pixel1, want.pixel2, want.pixel3};
          h = '{out_data.pixel0, out_data.pixel1, out_data.pixel2, out_data.pixel3};
          for (int k = 0; k < 4; k++) begin
            if (w[k] !== h[k]) begin
              errors++;
              $display("%0t pixel%0d expected %h actual %h", $time, k, w[k], h[k]);
            end
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // gain off: plain widening, peak still tracked
    write_gain(1'b0);
    offer(OP_MEASURE, 1'b1, 40'd0);
    offer(OP_CONVERT, 1'b0, 40'd0);
    offer(OP_CONVERT, 1'b0, {40{1'b1}});
    offer(OP_CONVERT, 1'b1, pack4(10'd1, 10'd512, 10'd15, 10'd16));
    offer(OP_MEASURE, 1'b1, pack4(10'd1023, 10'd3, 10'd0, 10'd7));
    offer(OP_MEASURE, 1'b0, pack4(10'd2, 10'd2, 10'd2, 10'd2));
    offer(OP_MEASURE, 1'b1, pack4(10'd100, 10'd37, 10'd0, 10'd5));
    offer(OP_CONVERT, 1'b0, pack4(10'd100, 10'd37, 10'd0, 10'd5));
    settle();

    // gain on: peak of 100 carried over from the gain-off measures
    write_gain(1'b1);
    offer(OP_CONVERT, 1'b0, pack4(10'd100, 10'd50, 10'd99, 10'd0));
    offer(OP_CONVERT, 1'b0, {40{1'b1}});
    offer(OP_CONVERT, 1'b1, pack4(10'd101, 10'd1, 10'd1023, 10'd33));
    offer(OP_MEASURE, 1'b1, 40'd0);
    offer(OP_CONVERT, 1'b0, pack4(10'd0, 10'd1, 10'd2, 10'd1023));
    offer(OP_MEASURE, 1'b1, {40{1'b1}});
    offer(OP_MEASURE, 1'b0, pack4(10'd5, 10'd6, 10'd7, 10'd8));
    offer(OP_CONVERT, 1'b1, pack4(10'd1023, 10'd512, 10'd1, 10'd0));
    offer(OP_MEASURE, 1'b1, pack4(10'd0, 10'd0, 10'd0, 10'd1));
    offer(OP_MEASURE, 1'b0, pack4(10'd0, 10'd700, 10'd0, 10'd0));
    offer(OP_CONVERT, 1'b0, pack4(10'd700, 10'd699, 10'd350, 10'd701));
    offer(OP_CONVERT, 1'b0, 40'haaaa_aaaa_aa);
    offer(OP_CONVERT, 1'b0, 40'h5555_5555_55);
    settle();

    write_gain(1'b1);
    random_phase(300);
    settle();
    write_gain(1'b0);
    burst_mode = 1'b1;
    random_phase(300);
    settle();
    burst_mode = 1'b0;
    write_gain(1'b1);
    random_phase(300);
    settle();
    write_gain(1'b0);
    random_phase(300);
    settle();
    write_gain(1'b1);
    burst_mode = 1'b1;
    random_phase(300);
    settle();
    burst_mode = 1'b0;
    random_phase(300);
    settle();

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
